// ===== src/config_text_tokenizer_assert.svh =====
// Assertion macros used by the tokenizer checker file
`ifndef CONFIG_TEXT_TOKENIZER_ASSERT_SVH
`define CONFIG_TEXT_TOKENIZER_ASSERT_SVH

// Same-cycle implication, switched off while reset is held
`define CTT_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tokenizer check failed");

// Next-cycle implication, switched off while reset is held
`define CTT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tokenizer check failed");

`endif

// ===== src/ctt_pkg.sv =====
// Types, codes and character classes of the configuration text tokenizer
`default_nettype none

package ctt_pkg;

    // lexer modes
    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_NUMBER  = 3'd1;
    localparam logic [2:0] M_ENTRY   = 3'd2;
    localparam logic [2:0] M_PRAGMA  = 3'd3;
    localparam logic [2:0] M_FIELD   = 3'd4;
    localparam logic [2:0] M_STRING  = 3'd5;
    localparam logic [2:0] M_COMMENT = 3'd6;

    // token kinds
    localparam logic [3:0] K_NUMBER = 4'd0;
    localparam logic [3:0] K_ENTRY  = 4'd1;
    localparam logic [3:0] K_PRAGMA = 4'd2;
    localparam logic [3:0] K_FIELD  = 4'd3;
    localparam logic [3:0] K_COLON  = 4'd4;
    localparam logic [3:0] K_COMMA  = 4'd5;
    localparam logic [3:0] K_STRING = 4'd6;
    localparam logic [3:0] K_ERROR  = 4'd7;
    localparam logic [3:0] K_TERM   = 4'd8;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_COLON  = 8'h3A;

    localparam int unsigned DECIMAL_BASE = 10;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] ch;
        logic       ch_valid;
        logic       last;
    } t_tok;

    // results produced by one input byte, up to two
    typedef struct packed {
        logic [1:0] count;
        t_tok       tok0;
        t_tok       tok1;
    } t_push;

    function automatic logic is_space(input logic [7:0] b);
        return b inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic t_tok mk_tok(input logic [3:0] kind, input logic [7:0] ch,
                                    input logic ch_valid, input logic last);
        t_tok t;
        t.kind     = kind;
        t.ch       = ch;
        t.ch_valid = ch_valid;
        t.last     = last;
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== src/ctt_lexer.sv =====
// Lexer state and per-byte decode into up to two tokens
`default_nettype none

module ctt_lexer import ctt_pkg::*; #(
    parameter int NUMBER_WIDTH = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_take,
    input  wire logic [7:0]              i_text_byte,
    output t_push                        o_push,
    output logic      [NUMBER_WIDTH-1:0] o_value0
);

    typedef struct packed {
        logic       emit;
        t_tok       tok;
        logic [2:0] mode;
        logic       start_num;
    } t_between;

    logic [2:0]              r_mode, n_mode;
    logic [NUMBER_WIDTH-1:0] r_acc, n_acc;
    logic [NUMBER_WIDTH-1:0] digit, acc_x10;
    t_between                btw;
    t_push                   push;
    logic [3:0]              text_kind;

    function automatic t_between between(input logic [7:0] b);
        t_between r;
        r.emit      = 1'b0;
        r.tok       = '0;
        r.mode      = M_IDLE;
        r.start_num = 1'b0;
        if (b == CH_NUL) begin
            r.emit = 1'b1;
            r.tok  = mk_tok(K_TERM, CH_NUL, 1'b0, 1'b1);
        end else if (is_space(b)) begin
            r.emit = 1'b0;
        end else if (is_digit(b)) begin
            r.mode      = M_NUMBER;
            r.start_num = 1'b1;
        end else if (is_letter(b)) begin
            r.mode = M_ENTRY;
            r.emit = 1'b1;
            r.tok  = mk_tok(K_ENTRY, b, 1'b1, 1'b0);
        end else begin
            case (b)
                CH_HASH:   r.mode = M_PRAGMA;
                CH_DOLLAR: r.mode = M_FIELD;
                CH_QUOTE:  r.mode = M_STRING;
                CH_SLASH:  r.mode = M_COMMENT;
                CH_COLON: begin
                    r.emit = 1'b1;
                    r.tok  = mk_tok(K_COLON, CH_NUL, 1'b0, 1'b1);
                end
                CH_COMMA: begin
                    r.emit = 1'b1;
                    r.tok  = mk_tok(K_COMMA, CH_NUL, 1'b0, 1'b1);
                end
                default: begin
                    r.emit = 1'b1;
                    r.tok  = mk_tok(K_ERROR, b, 1'b1, 1'b1);
                end
            endcase
        end
        return r;
    endfunction

    always_comb begin
        btw       = between(i_text_byte);
        digit     = NUMBER_WIDTH'(i_text_byte[3:0]);
        acc_x10   = (r_acc << 3) + (r_acc << 1);
        text_kind = (r_mode == M_ENTRY) ? K_ENTRY : K_PRAGMA;
        n_mode    = r_mode;
        n_acc     = r_acc;
        push      = '0;
        o_value0  = '0;
        case (r_mode)
            M_NUMBER: begin
                if (is_digit(i_text_byte)) begin
                    n_acc = acc_x10 + digit;
                end else begin
                    // number closes, then the byte is decoded afresh
                    push.count = 2'd1;
                    push.tok0  = mk_tok(K_NUMBER, CH_NUL, 1'b0, 1'b1);
                    o_value0   = r_acc;
                    n_mode     = btw.mode;
                    n_acc      = btw.start_num ? digit : '0;
                    if (btw.emit) begin
                        push.count = 2'd2;
                        push.tok1  = btw.tok;
                    end
                end
            end
            M_ENTRY, M_PRAGMA: begin
                push.count = 2'd1;
                if (i_text_byte == CH_NUL) begin
                    push.count = 2'd2;
                    push.tok0  = mk_tok(text_kind, CH_NUL, 1'b0, 1'b1);
                    push.tok1  = mk_tok(K_TERM, CH_NUL, 1'b0, 1'b1);
                    n_mode     = M_IDLE;
                    n_acc      = '0;
                end else if (is_space(i_text_byte)) begin
                    push.tok0 = mk_tok(text_kind, CH_NUL, 1'b0, 1'b1);
                    n_mode    = M_IDLE;
                end else begin
                    push.tok0 = mk_tok(text_kind, i_text_byte, 1'b1, 1'b0);
                end
            end
            M_FIELD: begin
                push.count = 2'd1;
                if (i_text_byte == CH_NUL) begin
                    push.count = 2'd2;
                    push.tok0  = mk_tok(K_FIELD, CH_NUL, 1'b0, 1'b1);
                    push.tok1  = mk_tok(K_TERM, CH_NUL, 1'b0, 1'b1);
                    n_mode     = M_IDLE;
                    n_acc      = '0;
                end else if (i_text_byte == CH_COLON) begin
                    push.count = 2'd2;
                    push.tok0  = mk_tok(K_FIELD, CH_NUL, 1'b0, 1'b1);
                    push.tok1  = mk_tok(K_COLON, CH_NUL, 1'b0, 1'b1);
                    n_mode     = M_IDLE;
                end else begin
                    push.tok0 = mk_tok(K_FIELD, i_text_byte, 1'b1, 1'b0);
                end
            end
            M_STRING: begin
                push.count = 2'd1;
                if (i_text_byte == CH_NUL) begin
                    push.count = 2'd2;
                    push.tok0  = mk_tok(K_STRING, CH_NUL, 1'b0, 1'b1);
                    push.tok1  = mk_tok(K_TERM, CH_NUL, 1'b0, 1'b1);
                    n_mode     = M_IDLE;
                    n_acc      = '0;
                end else if (i_text_byte == CH_QUOTE) begin
                    push.tok0 = mk_tok(K_STRING, CH_NUL, 1'b0, 1'b1);
                    n_mode    = M_IDLE;
                end else begin
                    push.tok0 = mk_tok(K_STRING, i_text_byte, 1'b1, 1'b0);
                end
            end
            M_COMMENT: begin
                if (i_text_byte == CH_NUL) begin
                    push.count = 2'd1;
                    push.tok0  = mk_tok(K_TERM, CH_NUL, 1'b0, 1'b1);
                    n_mode     = M_IDLE;
                    n_acc      = '0;
                end else if (i_text_byte == CH_NL) begin
                    n_mode = M_IDLE;
                end
            end
            default: begin
                n_mode     = btw.mode;
                push.count = {1'b0, btw.emit};
                push.tok0  = btw.tok;
                if (btw.start_num) begin
                    n_acc = digit;
                end else if (i_text_byte == CH_NUL) begin
                    n_acc = '0;
                end
            end
        endcase
        o_push = push;
        if (!i_take) begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_acc  <= '0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
        end
    end

endmodule

`default_nettype wire

// ===== src/ctt_outq.sv =====
// Four-entry result queue, two writes and one read per cycle
`default_nettype none

module ctt_outq import ctt_pkg::*; #(
    parameter int VALUE_W = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_push              i_push,
    input  wire logic [VALUE_W-1:0] i_value0,
    output logic                    o_room,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output t_tok                    o_tok,
    output logic      [VALUE_W-1:0] o_value
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    t_tok               r_tok [DEPTH];
    logic [VALUE_W-1:0] r_val [DEPTH];
    logic [AW-1:0]      r_wp, r_rp;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [AW-1:0]      wp_next;
    logic               pop;

    assign pop     = (r_cnt != '0) && i_ready;
    assign wp_next = r_wp + AW'(1);
    assign n_cnt   = r_cnt + CW'(i_push.count) - CW'(pop);
    // room for the worst case of two results from the next byte
    assign o_room  = (r_cnt <= CW'(DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_tok[r_rp];
    assign o_value = r_val[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_tok[r_wp] <= i_push.tok0;
            r_val[r_wp] <= i_value0;
        end
        if (i_push.count == 2'd2) begin
            r_tok[wp_next] <= i_push.tok1;
            r_val[wp_next] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + AW'(i_push.count);
            r_cnt <= n_cnt;
            if (pop) begin
                r_rp <= r_rp + AW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/config_text_tokenizer.sv =====
// Configuration text tokenizer: bytes in, tokens out
//
// Input channel: one text byte per transfer (i_valid / o_ready); byte 0 ends
// the text. Output channel: one token result per transfer (o_valid / i_ready)
// with kind, number value, character, character flag and last flag.
// A byte is decoded in the cycle it is accepted; its results, zero to two,
// are registered into a four-entry result queue and reach the outputs in
// order, behind any results still waiting there.
// Throughput is one byte per cycle while the receiver keeps up; a byte that
// yields two results (number followed by a token, text token ended by byte
// 0, field ended by a colon) leaves the queue read port of one result per
// cycle to set the sustained rate then.
// o_ready is high while the queue has space for two results, so when the
// receiver stalls the input backs up once more than two results wait; no
// result is dropped and payloads hold until taken.
// Reset empties the queue, puts the lexer between tokens and clears the
// number accumulator. Numbers wrap modulo 2**NUMBER_WIDTH.
`default_nettype none

module config_text_tokenizer import ctt_pkg::*; #(
    parameter int NUMBER_WIDTH = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [7:0]              i_text_byte,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic      [3:0]              o_token_kind,
    output logic      [NUMBER_WIDTH-1:0] o_number_value,
    output logic      [7:0]              o_char_out,
    output logic                         o_char_valid,
    output logic                         o_token_last
);

    logic                    take;
    t_push                   push;
    logic [NUMBER_WIDTH-1:0] value0;
    t_tok                    tok;

    assign take = i_valid && o_ready;

    ctt_lexer #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_lexer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_text_byte (i_text_byte),
        .o_push      (push),
        .o_value0    (value0)
    );

    ctt_outq #(
        .VALUE_W (NUMBER_WIDTH)
    ) u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_value0 (value0),
        .o_room   (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_tok    (tok),
        .o_value  (o_number_value)
    );

    assign o_token_kind = tok.kind;
    assign o_char_out   = tok.ch;
    assign o_char_valid = tok.ch_valid;
    assign o_token_last = tok.last;

endmodule

`default_nettype wire

// ===== src/ctt_checker.sv =====
// Port-level checks of the tokenizer and their binding to the top level
`default_nettype none

`include "config_text_tokenizer_assert.svh"

module ctt_checker import ctt_pkg::*; #(
    parameter int NUMBER_WIDTH = 16
) (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    o_valid,
    input wire logic                    i_ready,
    input wire logic [3:0]              o_token_kind,
    input wire logic [NUMBER_WIDTH-1:0] o_number_value,
    input wire logic [7:0]              o_char_out,
    input wire logic                    o_char_valid,
    input wire logic                    o_token_last
);

    `CTT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_token_kind))
    `CTT_ASSERT_NOW(a_value_only_number, i_clk, i_rst_n, o_valid && (o_token_kind != K_NUMBER), o_number_value == '0)
    `CTT_ASSERT_NOW(a_char_closes_error, i_clk, i_rst_n, o_valid && o_char_valid && o_token_last, o_token_kind == K_ERROR)
    `CTT_ASSERT_NOW(a_no_char_zeroed, i_clk, i_rst_n, o_valid && !o_char_valid, (o_char_out == CH_NUL) && o_token_last)

endmodule

bind config_text_tokenizer ctt_checker #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
) u_ctt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_token_kind   (o_token_kind),
    .o_number_value (o_number_value),
    .o_char_out     (o_char_out),
    .o_char_valid   (o_char_valid),
    .o_token_last   (o_token_last)
);

`default_nettype wire

// ===== sim/config_text_tokenizer_test.sv =====
`timescale 1ns / 100ps
// Testbench for the configuration text tokenizer: random text bytes against a token predictor
module config_text_tokenizer_test;
    import ctt_pkg::*;

    localparam int NUM_W           = 16;
    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct packed {
        logic [3:0]       kind;
        logic [NUM_W-1:0] value;
        logic [7:0]       ch;
        logic             ch_valid;
        logic             last;
    } t_token;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_valid     = 1'b0;
    logic [7:0]       i_text_byte = 8'h00;
    logic             i_ready     = 1'b0;
    logic             o_ready;
    logic             o_valid;
    logic [3:0]       o_token_kind;
    logic [NUM_W-1:0] o_number_value;
    logic [7:0]       o_char_out;
    logic             o_char_valid;
    logic             o_token_last;

    config_text_tokenizer #(.NUMBER_WIDTH(NUM_W)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_text_byte    (i_text_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_kind   (o_token_kind),
        .o_number_value (o_number_value),
        .o_char_out     (o_char_out),
        .o_char_valid   (o_char_valid),
        .o_token_last   (o_token_last)
    );

    always #5 i_clk = ~i_clk;

    t_token           pending_tokens[$];
    logic [2:0]       lex_mode      = M_IDLE;
    logic [NUM_W-1:0] number_acc    = '0;
    int               errors        = 0;
    int               bytes_sent    = 0;
    bit               no_idle       = 1'b0;
    int               hold_off_seq  = 0;
    int               hold_off_seen = 0;
    int               hold_off_left = 0;
    int               rx_gap_left   = 0;
    int               quiet_cycles  = 0;

    // ---------------------------------------------------------------- token predictor

    function automatic bit is_blank(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic bit is_numeral(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic bit is_alpha(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function void queue_token(input logic [3:0] kind, input logic [NUM_W-1:0] value,
                              input logic [7:0] ch, input logic ch_valid, input logic last);
        t_token t;
        t.kind     = kind;
        t.value    = value;
        t.ch       = ch;
        t.ch_valid = ch_valid;
        t.last     = last;
        pending_tokens.push_back(t);
    endfunction

    function void end_of_text();
        lex_mode   = M_IDLE;
        number_acc = '0;
        queue_token(K_TERM, '0, 8'h00, 1'b0, 1'b1);
    endfunction

    // byte seen with the lexer between tokens
    function void start_token(input logic [7:0] b);
        lex_mode = M_IDLE;
        if (b == CH_NUL) begin
            end_of_text();
        end else if (is_numeral(b)) begin
            lex_mode   = M_NUMBER;
            number_acc = NUM_W'(b - CH_ZERO);
        end else if (is_alpha(b)) begin
            lex_mode = M_ENTRY;
            queue_token(K_ENTRY, '0, b, 1'b1, 1'b0);
        end else if (!is_blank(b)) begin
            case (b)
                CH_HASH:   lex_mode = M_PRAGMA;
                CH_DOLLAR: lex_mode = M_FIELD;
                CH_QUOTE:  lex_mode = M_STRING;
                CH_SLASH:  lex_mode = M_COMMENT;
                CH_COLON:  queue_token(K_COLON, '0, 8'h00, 1'b0, 1'b1);
                CH_COMMA:  queue_token(K_COMMA, '0, 8'h00, 1'b0, 1'b1);
                default:   queue_token(K_ERROR, '0, b, 1'b1, 1'b1);
            endcase
        end
    endfunction

    function void predict_byte(input logic [7:0] b);
        logic [3:0] kind;
        case (lex_mode)
            M_NUMBER: begin
                if (is_numeral(b)) begin
                    number_acc = NUM_W'(number_acc * DECIMAL_BASE + (b - CH_ZERO));
                end else begin
                    queue_token(K_NUMBER, number_acc, 8'h00, 1'b0, 1'b1);
                    number_acc = '0;
                    start_token(b);
                end
            end
            M_ENTRY, M_PRAGMA: begin
                kind = (lex_mode == M_ENTRY) ? K_ENTRY : K_PRAGMA;
                if (b == CH_NUL) begin
                    queue_token(kind, '0, 8'h00, 1'b0, 1'b1);
                    end_of_text();
                end else if (is_blank(b)) begin
                    lex_mode = M_IDLE;
                    queue_token(kind, '0, 8'h00, 1'b0, 1'b1);
                end else begin
                    queue_token(kind, '0, b, 1'b1, 1'b0);
                end
            end
            M_FIELD: begin
                if (b == CH_NUL) begin
                    queue_token(K_FIELD, '0, 8'h00, 1'b0, 1'b1);
                    end_of_text();
                end else if (b == CH_COLON) begin
                    lex_mode = M_IDLE;
                    queue_token(K_FIELD, '0, 8'h00, 1'b0, 1'b1);
                    queue_token(K_COLON, '0, 8'h00, 1'b0, 1'b1);
                end else begin
                    queue_token(K_FIELD, '0, b, 1'b1, 1'b0);
                end
            end
            M_STRING: begin
                if (b == CH_NUL) begin
                    queue_token(K_STRING, '0, 8'h00, 1'b0, 1'b1);
                    end_of_text();
                end else if (b == CH_QUOTE) begin
                    lex_mode = M_IDLE;
                    queue_token(K_STRING, '0, 8'h00, 1'b0, 1'b1);
                end else begin
                    queue_token(K_STRING, '0, b, 1'b1, 1'b0);
                end
            end
            M_COMMENT: begin
                if (b == CH_NUL) begin
                    end_of_text();
                end else if (b == CH_NL) begin
                    lex_mode = M_IDLE;
                end
            end
            default: start_token(b);
        endcase
    endfunction

    // ---------------------------------------------------------------- sender

    // mostly no gap, a few short ones, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_text_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        predict_byte(b);
        bytes_sent++;
    endtask

    function automatic logic [7:0] pick_char(input logic [7:0] stop, input bit no_blank);
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == stop || (no_blank && is_blank(b)));
        return b;
    endfunction

    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'(8'h41 + r) : 8'(8'h61 + r - 26);
    endfunction

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'h20 : 8'(8'h09 + r);
    endfunction

    // text body of a token, then, for a closed token, its closing byte most of the time
    task automatic send_body(input logic [7:0] stop, input bit no_blank, input bit closed);
        int n;
        n = $urandom_range(0, 5);
        repeat (n) send_byte(pick_char(stop, no_blank));
        if (closed && $urandom_range(0, 9) != 0) send_byte(stop);
    endtask

    // one well-formed token most of the time, with noise and cut-off text mixed in
    task automatic send_fragment();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 18) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom_range(8'h30, 8'h39)));
        end else if (r < 32) begin
            send_byte(pick_letter());
            send_body(CH_NUL, 1'b1, 1'b0);
        end else if (r < 42) begin
            send_byte(CH_HASH);
            send_body(CH_NUL, 1'b1, 1'b0);
        end else if (r < 54) begin
            send_byte(CH_DOLLAR);
            send_body(CH_COLON, 1'b0, 1'b1);
        end else if (r < 66) begin
            send_byte(CH_QUOTE);
            send_body(CH_QUOTE, 1'b0, 1'b1);
        end else if (r < 72) begin
            send_byte(CH_SLASH);
            send_body(CH_NL, 1'b0, 1'b1);
        end else if (r < 78) begin
            send_byte(CH_COLON);
        end else if (r < 84) begin
            send_byte(CH_COMMA);
        end else if (r < 95) begin
            send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_byte(CH_NUL);
        end
        if ($urandom_range(0, 9) < 7) send_byte(pick_blank());
    endtask

    // ---------------------------------------------------------------- receiver and checker

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_token();
        t_token want;
        if (pending_tokens.size() == 0) begin
            $display("%0t: unexpected token, expected none, actual kind %0d char %0h",
                     $time, o_token_kind, o_char_out);
            errors++;
        end else begin
            want = pending_tokens.pop_front();
            compare_field("token_kind", 32'(want.kind), 32'(o_token_kind));
            compare_field("number_value", 32'(want.value), 32'(o_number_value));
            compare_field("char_out", 32'(want.ch), 32'(o_char_out));
            compare_field("char_valid", 32'(want.ch_valid), 32'(o_char_valid));
            compare_field("token_last", 32'(want.last), 32'(o_token_last));
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) check_token();
            if (hold_off_seq != hold_off_seen) begin
                hold_off_seen <= hold_off_seq;
                hold_off_left <= HOLD_OFF_CYCLES;
                i_ready       <= 1'b0;
            end else if (hold_off_left != 0) begin
                hold_off_left <= hold_off_left - 1;
                i_ready       <= 1'b0;
            end else if (rx_gap_left != 0) begin
                rx_gap_left <= rx_gap_left - 1;
                i_ready     <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!no_idle) rx_gap_left <= pick_gap();
            end
        end
    end

    // watchdog: cycles without any transfer on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("** config_text_tokenizer: FAILED **");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // wrapping number, every token kind, comment, high error bytes, number cut by end of text
    task automatic test_directed();
        logic [7:0] text [25];
        text = '{"6", "5", "5", "3", "6", ",", "A", "1", " ", "#", "p", " ", "$", "f", ":",
                 8'h22, "s", 8'h22, "/", "c", 8'h0A, 8'h80, 8'hFF, "7", 8'h00};
        foreach (text[i]) send_byte(text[i]);
    endtask

    task automatic test_random_text(input int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target) send_fragment();
    endtask

    task automatic test_steady_stream(input int count);
        no_idle <= 1'b1;
        test_random_text(count);
        no_idle <= 1'b0;
    endtask

    // receiver holds off while bytes keep coming, so the result queue fills up
    task automatic test_output_stall(input int count);
        no_idle      <= 1'b1;
        hold_off_seq <= hold_off_seq + 1;
        test_random_text(count);
        no_idle      <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_text(500);
        test_steady_stream(200);
        test_output_stall(150);
        test_random_text(575);
        i_valid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("** config_text_tokenizer: PASSED **");
        end else begin
            $display("** config_text_tokenizer: FAILED **");
        end
        $finish;
    end

endmodule
